/* sv/fpsa_pkg.sv */
// Shared types and constants for the free page stack allocator.
package fpsa_pkg;

	// Request kinds
	localparam logic [1:0] REQ_ADD   = 2'd0;
	localparam logic [1:0] REQ_ALLOC = 2'd1;
	localparam logic [1:0] REQ_FREE  = 2'd2;
	localparam logic [1:0] REQ_QUERY = 2'd3;

	// Result status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_OVF   = 2'd2;
	localparam logic [1:0] STAT_INDEX = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_PAGE_BITS    = 2'd0;
	localparam logic [1:0] CFG_KERNEL_START = 2'd1;
	localparam logic [1:0] CFG_KERNEL_END   = 2'd2;
	localparam logic [1:0] CFG_LOW_RESERVE  = 2'd3;

	// Configuration reset values and page size limits
	localparam logic [4:0]  PAGE_BITS_RST   = 5'd12;
	localparam logic [31:0] LOW_RESERVE_RST = 32'h0010_0000;
	localparam logic [4:0]  PAGE_BITS_MIN   = 5'd4;
	localparam logic [4:0]  PAGE_BITS_MAX   = 5'd22;
	localparam logic [31:0] ADDR_TOP        = 32'hffff_ffff;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  region_type;
		logic [31:0] region_base;
		logic [31:0] region_length;
		logic [31:0] freed_page;
		logic [11:0] entry_index;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] page_out;
		logic [12:0] pages_added;
		logic [12:0] free_count;
	} rsp_t;

	// Sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_END,
		S_RESERVE,
		S_KERNEL,
		S_ALIGN,
		S_PUSH,
		S_RESP
	} state_t;

	// Operands of the shared add / compare unit
	typedef struct packed {
		logic [32:0] add_a;
		logic [32:0] add_b;
		logic [32:0] cmp_a;
		logic [32:0] cmp_b;
	} alu_in_t;

	typedef struct packed {
		logic [32:0] sum;
		logic        lt;
	} alu_out_t;

endpackage

/* sv/fpsa_alu.sv */
// Shared 33-bit adder and magnitude comparator used by the sequencer.
module fpsa_alu
	import fpsa_pkg::*;
(
	input  alu_in_t  alu_in,
	output alu_out_t alu_out
);

	assign alu_out.sum = 33'(alu_in.add_a + alu_in.add_b);
	assign alu_out.lt  = (alu_in.cmp_a < alu_in.cmp_b);

endmodule

/* sv/free_page_stack_allocator_core.sv */
// Top level of the free page stack allocator: sequencer, stack memory, registers.
//
// Channel   Dir   Handshake                 Payload
// ------    ---   ----------------------    ---------------------------------
// in        in    in_valid / in_ready       in_data  (req_t)
// out       out   out_valid / out_ready     out_data (rsp_t)
// cfg       in    cfg_wr_en (no wait)       cfg_index, cfg_data
//
// Allocate, free, query and unusable regions go from accept straight to the response load.
// Add region: accept, end clamp, reserve clip, kernel clip, align, then per piece the
// pages pushed one by one and a closing compare (a split adds a second align), then
// the response load; a region wholly below the reserve, or a full stack, ends it early.
// Reset clears count, sequencer, config and output valid; the page store is not cleared.
// in_ready is high only in idle; a full output register holds the response state.
module free_page_stack_allocator_core
	import fpsa_pkg::*;
#(
	parameter int STACK_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  req_t        in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output rsp_t        out_data,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int CW   = $clog2(STACK_DEPTH + 1);   // count width, holds DEPTH
	localparam int AW   = $clog2(STACK_DEPTH);       // memory address width
	localparam int CMPW = (CW > 12) ? CW : 12;       // query compare width

	// Configuration registers
	logic [4:0]  page_bits_q;
	logic [31:0] kstart_q;
	logic [31:0] kend_q;
	logic [31:0] lreserve_q;

	// Sequencer and working registers
	state_t         state_q, state_d;
	logic [CW-1:0]  count_q, count_d;
	logic [CW-1:0]  added_q, added_d;
	logic [1:0]     status_q, status_d;
	logic           use_rd_q, use_rd_d;
	logic [31:0]    lo_q, lo_d;       // region low bound; later unused
	logic [31:0]    hi_q, hi_d;       // holds length, then clamped end
	logic [31:0]    cur_s_q, cur_s_d; // current piece, first/last byte
	logic [31:0]    cur_e_q, cur_e_d;
	logic [31:0]    nxt_s_q, nxt_s_d; // second piece after a kernel split
	logic [31:0]    nxt_e_q, nxt_e_d;
	logic           two_q, two_d;
	logic [32:0]    addr_q, addr_d;   // next page address to push
	logic [31:0]    end_q, end_d;     // push while addr < end

	// Output register
	logic        out_valid_q;
	rsp_t        out_q;
	logic        out_load;

	// Stack memory
	logic [31:0]   mem [STACK_DEPTH];
	logic [31:0]   rdata_q;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [31:0]   mem_wdata;

	// Shared arithmetic unit
	alu_in_t  alu_in;
	alu_out_t alu_out;

	fpsa_alu u_alu (
		.alu_in  (alu_in),
		.alu_out (alu_out)
	);

	// Page geometry from the clamped page size
	logic [4:0]  pb_eff;
	logic [32:0] page_sz;
	logic [31:0] mask;
	assign pb_eff  = (page_bits_q < PAGE_BITS_MIN) ? PAGE_BITS_MIN :
		((page_bits_q > PAGE_BITS_MAX) ? PAGE_BITS_MAX : page_bits_q);
	assign page_sz = 33'd1 << pb_eff;
	assign mask    = page_sz[31:0] - 32'd1;

	logic in_fire, full;
	assign in_fire = in_valid && in_ready;
	assign full    = (count_q == CW'(STACK_DEPTH));

	// Region clipping compares
	logic below_res, hi_le_res;
	logic ks_le_lo, ke_ge_lo, ke_lt_hi, ks_le_hi, ke_ge_hi;
	assign below_res = lo_q < lreserve_q;
	assign hi_le_res = hi_q <= lreserve_q;
	assign ks_le_lo  = kstart_q <= lo_q;
	assign ke_ge_lo  = kend_q >= lo_q;
	assign ke_lt_hi  = kend_q < hi_q;
	assign ks_le_hi  = kstart_q <= hi_q;
	assign ke_ge_hi  = kend_q >= hi_q;

	// Piece alignment: end rounded down to a whole page
	logic [31:0] e_al;
	logic        e_partial, piece_empty;
	assign e_al        = cur_e_q & ~mask;
	assign e_partial   = (cur_e_q & mask) != mask;
	assign piece_empty = e_partial && (e_al == 32'd0);

	assign in_ready = (state_q == S_IDLE);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					if (in_data.req_type == REQ_ADD && in_data.region_type == 8'd1)
						state_d = S_END;
					else
						state_d = S_RESP;
				end
			end
			S_END:     state_d = S_RESERVE;
			S_RESERVE: state_d = (below_res && hi_le_res) ? S_RESP : S_KERNEL;
			S_KERNEL:  state_d = S_ALIGN;
			S_ALIGN: begin
				if (!piece_empty)
					state_d = S_PUSH;
				else if (!two_q)
					state_d = S_RESP;
			end
			S_PUSH: begin
				if (alu_out.lt)
					state_d = full ? S_RESP : S_PUSH;
				else
					state_d = two_q ? S_ALIGN : S_RESP;
			end
			S_RESP: begin
				if (!out_valid_q || out_ready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Datapath controls
	always_comb begin
		count_d   = count_q;
		added_d   = added_q;
		status_d  = status_q;
		use_rd_d  = use_rd_q;
		lo_d      = lo_q;
		hi_d      = hi_q;
		cur_s_d   = cur_s_q;
		cur_e_d   = cur_e_q;
		nxt_s_d   = nxt_s_q;
		nxt_e_d   = nxt_e_q;
		two_d     = two_q;
		addr_d    = addr_q;
		end_d     = end_q;
		mem_we    = 1'b0;
		mem_waddr = count_q[AW-1:0];
		mem_wdata = addr_q[31:0];
		mem_re    = 1'b0;
		mem_raddr = '0;
		alu_in    = '0;
		out_load  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					added_d  = '0;
					status_d = STAT_OK;
					use_rd_d = 1'b0;
					two_d    = 1'b0;
					lo_d     = in_data.region_base;
					hi_d     = in_data.region_length;
					unique case (in_data.req_type)
						REQ_ADD: ;
						REQ_ALLOC: begin
							if (count_q == '0) begin
								status_d = STAT_EMPTY;
							end else begin
								count_d   = count_q - CW'(1);
								mem_re    = 1'b1;
								mem_raddr = AW'(count_q - CW'(1));
								use_rd_d  = 1'b1;
							end
						end
						REQ_FREE: begin
							if (full) begin
								status_d = STAT_OVF;
							end else begin
								mem_we    = 1'b1;
								mem_wdata = in_data.freed_page;
								count_d   = count_q + CW'(1);
							end
						end
						REQ_QUERY: begin
							if (CMPW'(in_data.entry_index) < CMPW'(count_q)) begin
								mem_re    = 1'b1;
								mem_raddr = AW'(in_data.entry_index);
								use_rd_d  = 1'b1;
							end else begin
								status_d = STAT_INDEX;
							end
						end
						default: ;
					endcase
				end
			end
			S_END: begin
				// end = base + length, saturated at the top of the space
				alu_in.add_a = {1'b0, lo_q};
				alu_in.add_b = {1'b0, hi_q};
				hi_d = alu_out.sum[32] ? ADDR_TOP : alu_out.sum[31:0];
			end
			S_RESERVE: begin
				if (below_res && !hi_le_res)
					lo_d = lreserve_q;
			end
			S_KERNEL: begin
				cur_s_d = lo_q;
				cur_e_d = hi_q;
				if (ks_le_lo) begin
					if (ke_ge_lo)
						cur_s_d = ke_lt_hi ? kend_q + 32'd1 : hi_q;
				end else if (ks_le_hi) begin
					if (ke_ge_hi) begin
						cur_e_d = kstart_q - 32'd1;
					end else begin
						// kernel sits inside: two pieces
						cur_e_d = kstart_q - 32'd1;
						nxt_s_d = kend_q + 32'd1;
						nxt_e_d = hi_q;
						two_d   = 1'b1;
					end
				end
			end
			S_ALIGN: begin
				alu_in.add_a = {1'b0, cur_s_q | mask};
				alu_in.add_b = 33'd1;
				addr_d = ((cur_s_q & mask) != 32'd0) ? alu_out.sum : {1'b0, cur_s_q};
				end_d  = e_partial ? e_al - 32'd1 : cur_e_q;
				if (piece_empty && two_q) begin
					cur_s_d = nxt_s_q;
					cur_e_d = nxt_e_q;
					two_d   = 1'b0;
				end
			end
			S_PUSH: begin
				alu_in.add_a = addr_q;
				alu_in.add_b = page_sz;
				alu_in.cmp_a = addr_q;
				alu_in.cmp_b = {1'b0, end_q};
				if (alu_out.lt) begin
					if (full) begin
						status_d = STAT_OVF;
					end else begin
						mem_we  = 1'b1;
						count_d = count_q + CW'(1);
						added_d = added_q + CW'(1);
						addr_d  = alu_out.sum;
					end
				end else if (two_q) begin
					cur_s_d = nxt_s_q;
					cur_e_d = nxt_e_q;
					two_d   = 1'b0;
				end
			end
			S_RESP: begin
				out_load = !out_valid_q || out_ready;
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			two_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			two_q   <= two_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_bits_q <= PAGE_BITS_RST;
			kstart_q    <= '0;
			kend_q      <= '0;
			lreserve_q  <= LOW_RESERVE_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_PAGE_BITS:    page_bits_q <= cfg_data[4:0];
				CFG_KERNEL_START: kstart_q    <= cfg_data;
				CFG_KERNEL_END:   kend_q      <= cfg_data;
				CFG_LOW_RESERVE:  lreserve_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Working payload registers
	always_ff @(posedge clk) begin
		added_q  <= added_d;
		status_q <= status_d;
		use_rd_q <= use_rd_d;
		lo_q     <= lo_d;
		hi_q     <= hi_d;
		cur_s_q  <= cur_s_d;
		cur_e_q  <= cur_e_d;
		nxt_s_q  <= nxt_s_d;
		nxt_e_q  <= nxt_e_d;
		addr_q   <= addr_d;
		end_q    <= end_d;
		if (out_load) begin
			out_q.status      <= status_q;
			out_q.page_out    <= use_rd_q ? rdata_q : 32'd0;
			out_q.pages_added <= 13'(added_q);
			out_q.free_count  <= 13'(count_q);
		end
	end

	// Stack memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			rdata_q <= mem[mem_raddr];
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* sv/fpsa_checker.sv */
// Port-level assertions for the allocator core, bound to the top level.
module fpsa_sva
	import fpsa_pkg::*;
#(
	parameter int STACK_DEPTH = 4096
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input req_t        in_data,
	input logic        out_valid,
	input logic        out_ready,
	input rsp_t        out_data
);

	// a waiting request holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("request changed while waiting");

	// a stalled response holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("response changed while stalled");

	// the reported count never exceeds the stack depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (STACK_DEPTH >= 8192) || (out_data.free_count <= STACK_DEPTH))
		else $error("free_count above stack depth");

	// an empty pop reports an empty stack and no page
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == STAT_EMPTY |->
			out_data.page_out == 32'd0 && out_data.free_count == 13'd0
			&& out_data.pages_added == 13'd0)
		else $error("empty status with page or count");

	// a bad query index gives no page and adds nothing
	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == STAT_INDEX |->
			out_data.page_out == 32'd0 && out_data.pages_added == 13'd0)
		else $error("index status with page");

endmodule

bind free_page_stack_allocator_core fpsa_sva #(.STACK_DEPTH(STACK_DEPTH)) u_fpsa_chk (.*);
